/* sv/crp_pkg.sv */
`timescale 1ns / 1ps
// ============================================================================
// crp_pkg - shared definitions for the reference-counted cluster pool
// Request and status codes, port widths and default pool dimensions.
// ============================================================================
package crp_pkg;

  // Default pool dimensions.
  localparam int DEF_CLUSTERS = 256;
  localparam int DEF_REF_BITS = 8;

  // Fixed widths of the request and result fields.
  localparam int IDX_IN_W = 8;
  localparam int STAT_W   = 3;
  localparam int OCC_W    = 9;
  localparam int CNT_OUT_W = 8;

  typedef enum logic [1:0] {
    ACT_ALLOC   = 2'd0,
    ACT_RELEASE = 2'd1,
    ACT_ADDREF  = 2'd2,
    ACT_UNKNOWN = 2'd3
  } action_t;

  typedef enum logic [STAT_W-1:0] {
    ST_ALLOCATED = 3'd0,
    ST_EXHAUSTED = 3'd1,
    ST_STILL_REF = 3'd2,
    ST_RETURNED  = 3'd3,
    ST_REF_ADDED = 3'd4,
    ST_ERROR     = 3'd5
  } status_t;

  // Updates that one request applies to the pool state.
  typedef struct packed {
    logic pop;        // take the top of the free stack
    logic push;       // return the cluster to the free stack
    logic alloc_dec;  // one fewer cluster in use
    logic cnt_we;     // write the count memory
    logic wr_got;     // count write goes to the popped cluster
  } upd_t;

endpackage

/* sv/refcounted_cluster_pool_top.sv */
`timescale 1ns / 1ps
// ============================================================================
// refcounted_cluster_pool_top - reference-counted cluster pool
// LIFO free stack of buffer clusters with a per-cluster reference count.
// ============================================================================
// Each request has a read step and a write-back step: at the accepting edge
// the top of the free stack and the named cluster's count are read from their
// RAMs, and at the next edge the request is decided, the RAMs are written back
// and the result beat is loaded into the output register. The next request
// can be accepted in the cycle after that, as the stack and count memories
// have registered reads; a held result beat can delay it. Because a request
// is never accepted while the previous one is writing back, no read can
// overlap a write to the same entry and no forwarding is needed. There is
// no clearing pass after reset: a low-water mark records the smallest stack
// depth ever reached. Stack slots below that mark have never been rewritten
// and still hold their reset contents, so a pop from a fresh slot yields the
// slot's own position, and a cluster whose index lies below the mark has
// never been handed out and reads with a count of zero. The block accepts
// requests from the first cycle after reset. A result beat waiting in the
// output register blocks the next request only while the downstream side
// holds out_stall.
// ============================================================================
module refcounted_cluster_pool_top
  import crp_pkg::*;
#(
  parameter int CLUSTERS = DEF_CLUSTERS,
  parameter int REF_BITS = DEF_REF_BITS
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [1:0]           action,
  input  logic [IDX_IN_W-1:0]  cluster_index,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [IDX_IN_W-1:0]  granted_index,
  output logic [STAT_W-1:0]    status,
  output logic [CNT_OUT_W-1:0] ref_count,
  output logic [OCC_W-1:0]     in_use,
  output logic [OCC_W-1:0]     free_count,
  output logic [OCC_W-1:0]     high_water
);

  localparam int IDX_W  = $clog2(CLUSTERS);
  localparam int CNT_W  = $clog2(CLUSTERS + 1);
  localparam int WIDE_W = (IDX_W > IDX_IN_W) ? IDX_W : IDX_IN_W;
  localparam logic [CNT_W-1:0] FULL_DEPTH = CNT_W'(CLUSTERS);

  // Request handshake and the request held for the write-back cycle.
  logic                in_acc;
  logic                busy;
  action_t             act_q;
  logic [IDX_IN_W-1:0] idx_q;
  logic [IDX_W-1:0]    idx_addr_q;
  logic                in_range_q;

  // Pool state kept in flip-flops.
  logic [CNT_W-1:0] depth;
  logic [CNT_W-1:0] depth_next;
  logic [CNT_W-1:0] alloc_count;
  logic [CNT_W-1:0] alloc_count_next;
  logic [CNT_W-1:0] peak_alloc;
  logic [CNT_W-1:0] peak_alloc_next;
  logic [CNT_W-1:0] low_mark;
  logic [CNT_W-1:0] low_mark_next;

  // Address forming on the accepting edge.
  logic [WIDE_W-1:0] idx_wide;
  logic [IDX_W-1:0]  idx_addr;
  logic              in_range;
  logic [CNT_W-1:0]  depth_m1;
  logic              empty;
  logic [IDX_W-1:0]  stk_raddr;
  logic [IDX_W-1:0]  cnt_raddr;

  // RAM ports.
  logic [IDX_W-1:0]    stk_rdata;
  logic                stk_we;
  logic [IDX_W-1:0]    stk_waddr;
  logic [REF_BITS-1:0] cnt_rdata;
  logic                cnt_we;
  logic [IDX_W-1:0]    cnt_waddr;

  // Write-back cycle.
  logic                fresh;
  logic [IDX_W-1:0]    got;
  logic [REF_BITS-1:0] cnt_res;
  upd_t                upd;
  status_t             dec_status;
  logic [REF_BITS-1:0] cnt_wdata;
  logic [REF_BITS-1:0] res_cnt;
  logic [31:0]         got32;
  logic [31:0]         res_cnt32;
  logic [31:0]         depth32;
  logic [31:0]         alloc32;
  logic [31:0]         peak32;
  logic [IDX_IN_W-1:0] grant_sel;

  assign in_stall = busy | (out_valid & out_stall);
  assign in_acc   = in_valid & ~in_stall;

  assign idx_wide = WIDE_W'(cluster_index);
  assign idx_addr = idx_wide[IDX_W-1:0];
  assign in_range = 32'(cluster_index) < CLUSTERS;
  assign depth_m1 = depth - CNT_W'(1);
  assign empty    = (depth == '0);

  // Keep both read addresses inside the RAM even when the value is unused.
  assign stk_raddr = empty ? '0 : depth_m1[IDX_W-1:0];
  assign cnt_raddr = in_range ? idx_addr : '0;

  crp_ram #(
    .WIDTH (IDX_W),
    .DEPTH (CLUSTERS)
  ) u_stack_ram (
    .clk   (clk),
    .we    (stk_we),
    .waddr (stk_waddr),
    .wdata (idx_addr_q),
    .raddr (stk_raddr),
    .rdata (stk_rdata)
  );

  crp_ram #(
    .WIDTH (REF_BITS),
    .DEPTH (CLUSTERS)
  ) u_count_ram (
    .clk   (clk),
    .we    (cnt_we),
    .waddr (cnt_waddr),
    .wdata (cnt_wdata),
    .raddr (cnt_raddr),
    .rdata (cnt_rdata)
  );

  // A slot at the low-water mark has never been written since reset and
  // still holds its own position; a cluster below the mark was never issued.
  assign fresh   = (depth == low_mark);
  assign got     = fresh ? depth_m1[IDX_W-1:0] : stk_rdata;
  assign cnt_res = (32'(idx_q) < 32'(low_mark)) ? '0 : cnt_rdata;

  crp_decide #(
    .REF_BITS (REF_BITS)
  ) u_decide (
    .act       (act_q),
    .in_range  (in_range_q),
    .empty     (empty),
    .full      (depth == FULL_DEPTH),
    .alloc_nz  (alloc_count != '0),
    .cnt       (cnt_res),
    .upd       (upd),
    .status    (dec_status),
    .cnt_wdata (cnt_wdata),
    .res_cnt   (res_cnt)
  );

  assign stk_we    = busy & upd.push;
  assign stk_waddr = depth[IDX_W-1:0];
  assign cnt_we    = busy & upd.cnt_we;
  assign cnt_waddr = upd.wr_got ? got : idx_addr_q;

  always_comb begin
    depth_next       = depth;
    alloc_count_next = alloc_count;
    low_mark_next    = low_mark;
    if (upd.pop) begin
      depth_next       = depth_m1;
      alloc_count_next = alloc_count + CNT_W'(1);
      if (fresh) begin
        low_mark_next = depth_m1;
      end
    end else begin
      if (upd.push) begin
        depth_next = depth + CNT_W'(1);
      end
      if (upd.alloc_dec) begin
        alloc_count_next = alloc_count - CNT_W'(1);
      end
    end
    peak_alloc_next = (alloc_count_next > peak_alloc) ? alloc_count_next : peak_alloc;
  end

  assign got32     = 32'(got);
  assign res_cnt32 = 32'(res_cnt);
  assign depth32   = 32'(depth_next);
  assign alloc32   = 32'(alloc_count_next);
  assign peak32    = 32'(peak_alloc_next);

  // Exhaustion reports index zero; a successful allocate reports the popped
  // cluster; every other request echoes the requested index.
  always_comb begin
    if (upd.pop) begin
      grant_sel = got32[IDX_IN_W-1:0];
    end else if (dec_status == ST_EXHAUSTED) begin
      grant_sel = '0;
    end else begin
      grant_sel = idx_q;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy        <= 1'b0;
      out_valid   <= 1'b0;
      depth       <= FULL_DEPTH;
      low_mark    <= FULL_DEPTH;
      alloc_count <= '0;
      peak_alloc  <= '0;
    end else begin
      if (in_acc) begin
        busy <= 1'b1;
      end else if (busy) begin
        busy <= 1'b0;
      end
      if (busy) begin
        out_valid   <= 1'b1;
        depth       <= depth_next;
        low_mark    <= low_mark_next;
        alloc_count <= alloc_count_next;
        peak_alloc  <= peak_alloc_next;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Request and result payload registers.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      act_q      <= action_t'(action);
      idx_q      <= cluster_index;
      idx_addr_q <= idx_addr;
      in_range_q <= in_range;
    end
    if (busy) begin
      granted_index <= grant_sel;
      status        <= dec_status;
      ref_count     <= res_cnt32[CNT_OUT_W-1:0];
      in_use        <= alloc32[OCC_W-1:0];
      free_count    <= depth32[OCC_W-1:0];
      high_water    <= peak32[OCC_W-1:0];
    end
  end

  // Every cluster is either on the free stack or in use.
  a_conserve: assert property (@(posedge clk) disable iff (rst)
    32'(depth) + 32'(alloc_count) == CLUSTERS)
    else $error("free and in-use clusters do not add up to the pool size");

  // The high-water mark never falls below the current allocation.
  a_peak: assert property (@(posedge clk) disable iff (rst)
    peak_alloc >= alloc_count)
    else $error("high-water mark below current allocation");

  // The low-water mark never rises above the stack depth.
  a_low_mark: assert property (@(posedge clk) disable iff (rst)
    low_mark <= depth)
    else $error("low-water mark above stack depth");

  // Write-back ends at the next edge with a valid result and always finds the output free.
  a_one_wb: assert property (@(posedge clk) disable iff (rst)
    busy |=> !busy && out_valid)
    else $error("write-back did not complete in one cycle");

  a_out_free: assert property (@(posedge clk) disable iff (rst)
    busy |-> !(out_valid && out_stall))
    else $error("write-back while a result beat is held");

endmodule

/* sv/crp_ram.sv */
`timescale 1ns / 1ps
// ============================================================================
// crp_ram - generic single-write, single-read synchronous RAM
// One write port and one read port; read data is registered.
// ============================================================================
module crp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* sv/crp_decide.sv */
`timescale 1ns / 1ps
// ============================================================================
// crp_decide - request decision logic
// Maps a request and the looked-up count to a status, a result count and
// the set of state updates.
// ============================================================================
module crp_decide
  import crp_pkg::*;
#(
  parameter int REF_BITS = DEF_REF_BITS
) (
  input  action_t             act,
  input  logic                in_range,
  input  logic                empty,
  input  logic                full,
  input  logic                alloc_nz,
  input  logic [REF_BITS-1:0] cnt,
  output upd_t                upd,
  output status_t             status,
  output logic [REF_BITS-1:0] cnt_wdata,
  output logic [REF_BITS-1:0] res_cnt
);

  localparam logic [REF_BITS-1:0] REF_MAX = {REF_BITS{1'b1}};

  logic [REF_BITS-1:0] cnt_dec;
  logic [REF_BITS-1:0] cnt_inc;

  assign cnt_dec = cnt - REF_BITS'(1);
  assign cnt_inc = cnt + REF_BITS'(1);

  always_comb begin
    upd       = '0;
    status    = ST_ERROR;
    cnt_wdata = '0;
    res_cnt   = '0;
    unique case (act)
      ACT_ALLOC: begin
        if (empty) begin
          status = ST_EXHAUSTED;
        end else begin
          upd.pop    = 1'b1;
          upd.cnt_we = 1'b1;
          upd.wr_got = 1'b1;
          cnt_wdata  = REF_BITS'(1);
          res_cnt    = REF_BITS'(1);
          status     = ST_ALLOCATED;
        end
      end
      ACT_RELEASE: begin
        if (in_range && cnt != '0) begin
          upd.cnt_we = 1'b1;
          cnt_wdata  = cnt_dec;
          if (cnt_dec != '0) begin
            status  = ST_STILL_REF;
            res_cnt = cnt_dec;
          end else begin
            // Last reference gone: the cluster goes back on the stack unless it is full.
            upd.push      = !full;
            upd.alloc_dec = alloc_nz;
            status        = ST_RETURNED;
          end
        end
      end
      ACT_ADDREF: begin
        if (in_range) begin
          if (cnt == '0 || cnt == REF_MAX) begin
            res_cnt = cnt;
          end else begin
            upd.cnt_we = 1'b1;
            cnt_wdata  = cnt_inc;
            res_cnt    = cnt_inc;
            status     = ST_REF_ADDED;
          end
        end
      end
      ACT_UNKNOWN: begin
        res_cnt = in_range ? cnt : '0;
      end
    endcase
  end

endmodule
